FILE: sv/yaz0d_pkg.sv
// Shared types and constants of the Yaz0 decompressor.
package yaz0d_pkg;

	localparam int WINDOW_DEPTH = 4096;
	localparam int OUT_LANES    = 8;
	localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = WIN_AW + 1;
	localparam int LEN_W        = 9;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

	localparam logic [4:0] HEADER_BYTES = 5'd16;
	localparam logic [LEN_W-1:0] LONG_BIAS = 9'h012;
	localparam logic [0:0] REG_OUT_SIZE    = 1'b0;
	localparam logic [0:0] REG_SKIP_HEADER = 1'b1;

	// One command from the parser to the copy engine.
	typedef struct packed {
		logic             is_lit;
		logic [7:0]       lit_byte;
		logic [WIN_AW-1:0] dist_m1;
		logic [LEN_W-1:0] len;
		logic             new_stream;
		logic             done;
	} cmd_t;

	typedef enum logic [3:0] {
		PH_CODE   = 4'b0001,
		PH_FIRST  = 4'b0010,
		PH_SECOND = 4'b0100,
		PH_THIRD  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RD   = 3'b010,
		ST_PUT  = 3'b100
	} bstate_t;

endpackage

FILE: sv/yaz0_decompressor.sv
// Top level of the Yaz0 decompressor: parser, command queue and copy engine.
//
// Input channel: one compressed byte per request (data_byte), with
// start_of_stream marking the first byte of a stream. The block stalls the
// input only when its four-entry command queue is full.
// Output channel: each request carries up to eight bytes in out_bytes, the
// earliest in bits 7..0, byte_count valid lanes, last_of_run on the final
// request caused by one input byte and stream_done when out_size is reached.
// Processing: the parser takes header, code and reference bytes as accepted.
// A literal passes the copy engine's idle and put states; a back-reference
// passes idle, then a read and a put state per copied byte, set by the
// registered read of the single-port history memory. With an empty queue
// and no stall, a literal's request is registered after the queue, idle and
// put states; a back-reference's first request follows a read and a put for each
// of the 1 to 8 bytes in that request. Configuration (out_size, skip_header)
// is written through the cfg_wr_en/cfg_index/cfg_data port; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset clears the parser, queue and engine; the history memory is not
// cleared, since reads before the stream start return zero by count.
// When the receiver stalls, the output register holds its request and the
// engine pauses before finishing the next one; the queue fills behind it.
module yaz0_decompressor import yaz0d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_of_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_bytes,
	output logic [3:0]  byte_count,
	output logic        last_of_run,
	output logic        stream_done
);

	logic accept, push, pop, empty, full;
	cmd_t push_cmd, head_cmd;

	// The parser stalls whenever the queue could not take a command.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	yaz0d_front u_front (
		.clk, .arst_n, .cfg_wr_en, .cfg_index, .cfg_data,
		.accept, .data_byte, .start_of_stream, .push, .push_cmd
	);

	yaz0d_fifo u_fifo (
		.clk, .arst_n, .push, .push_cmd, .pop, .head_cmd, .empty, .full
	);

	yaz0d_back u_back (
		.clk, .arst_n, .head_cmd, .empty, .pop, .out_valid, .out_stall,
		.out_bytes, .byte_count, .last_of_run, .stream_done
	);

endmodule

FILE: sv/yaz0d_fifo.sv
// Small command queue between the parser and the copy engine.
module yaz0d_fifo import yaz0d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	cmd_t              entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/yaz0d_front.sv
// Parser: holds the configuration, walks the code bytes and issues commands.
module yaz0d_front import yaz0d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        start_of_stream,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [31:0] out_size_q;
	logic        skip_q;
	logic [31:0] prod_q, prod_e, prod_d, remaining;
	logic        fin_q, fin_e, fin_d, full_e;
	phase_t      ph_q, ph_e, ph_d;
	logic [3:0]  fl_q, fl_e, fl_d, fl_dec;
	logic [7:0]  fb_q, fb_e, fb_d, b1_q, b1_d, b2_q, b2_d;
	logic [4:0]  hdr_q, hdr_e, hdr_d;
	logic        pend_q, pend_d;
	logic [LEN_W-1:0] len_raw, clip_len;
	logic        take_cmd, is_lit, short_len;

	assign short_len = ({23'b0, len_raw} < remaining);
	assign clip_len  = short_len ? len_raw : remaining[LEN_W-1:0];
	assign fl_dec    = fl_e - 4'd1;

	always_comb begin
		prod_e = prod_q;
		fin_e  = fin_q;
		ph_e   = ph_q;
		fl_e   = fl_q;
		fb_e   = fb_q;
		hdr_e  = hdr_q;
		if (start_of_stream) begin
			prod_e = '0;
			fin_e  = 1'b0;
			ph_e   = PH_CODE;
			fl_e   = '0;
			fb_e   = '0;
			hdr_e  = skip_q ? HEADER_BYTES : 5'd0;
		end
		full_e    = fin_e || (prod_e >= out_size_q);
		remaining = out_size_q - prod_e;

		prod_d   = prod_e;
		fin_d    = fin_e;
		ph_d     = ph_e;
		fl_d     = fl_e;
		fb_d     = fb_e;
		hdr_d    = hdr_e;
		b1_d     = b1_q;
		b2_d     = b2_q;
		take_cmd = 1'b0;
		is_lit   = 1'b0;
		len_raw  = '0;

		if (!full_e) begin
			if (hdr_e != 5'd0) begin
				hdr_d = hdr_e - 5'd1;
			end else begin
				unique case (ph_e)
					PH_CODE: begin
						fb_d = data_byte;
						fl_d = 4'd8;
						ph_d = PH_FIRST;
					end
					PH_FIRST: begin
						if (fb_e[7]) begin
							take_cmd = 1'b1;
							is_lit   = 1'b1;
							len_raw  = 9'd1;
						end else begin
							b1_d = data_byte;
							ph_d = PH_SECOND;
						end
					end
					PH_SECOND: begin
						b2_d = data_byte;
						if (b1_q[7:4] == 4'd0) begin
							ph_d = PH_THIRD;
						end else begin
							take_cmd = 1'b1;
							len_raw  = {5'd0, b1_q[7:4]} + 9'd2;
						end
					end
					PH_THIRD: begin
						take_cmd = 1'b1;
						len_raw  = {1'b0, data_byte} + LONG_BIAS;
					end
					default: ph_d = PH_CODE;
				endcase
				if (take_cmd) begin
					fb_d   = {fb_e[6:0], 1'b0};
					fl_d   = fl_dec;
					ph_d   = (fl_dec == 4'd0) ? PH_CODE : PH_FIRST;
					prod_d = prod_e + {23'b0, clip_len};
					fin_d  = !short_len;
				end
			end
		end
		pend_d = (pend_q || start_of_stream) && !take_cmd;
	end

	assign push                = accept && take_cmd;
	assign push_cmd.is_lit     = is_lit;
	assign push_cmd.lit_byte   = data_byte;
	assign push_cmd.dist_m1    = {b1_q[3:0], (ph_e == PH_THIRD) ? b2_q : data_byte};
	assign push_cmd.len        = clip_len;
	assign push_cmd.new_stream = pend_q || start_of_stream;
	assign push_cmd.done       = !short_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_size_q <= '0;
			skip_q     <= 1'b1;
			prod_q     <= '0;
			fin_q      <= 1'b0;
			ph_q       <= PH_CODE;
			fl_q       <= '0;
			fb_q       <= '0;
			b1_q       <= '0;
			b2_q       <= '0;
			hdr_q      <= HEADER_BYTES;
			pend_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_OUT_SIZE) out_size_q <= cfg_data;
				if (cfg_index == REG_SKIP_HEADER) skip_q <= cfg_data[0];
			end
			if (accept) begin
				prod_q <= prod_d;
				fin_q  <= fin_d;
				ph_q   <= ph_d;
				fl_q   <= fl_d;
				fb_q   <= fb_d;
				b1_q   <= b1_d;
				b2_q   <= b2_d;
				hdr_q  <= hdr_d;
				pend_q <= pend_d;
			end
		end
	end

endmodule

FILE: sv/yaz0d_back.sv
// Copy engine: history memory, byte production and result packing.
module yaz0d_back import yaz0d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head_cmd,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_bytes,
	output logic [3:0]  byte_count,
	output logic        last_of_run,
	output logic        stream_done
);

	logic [7:0]        hist_mem [WINDOW_DEPTH];
	logic [7:0]        rd_data_q;
	bstate_t           st_q;
	logic [WIN_AW-1:0] wp_q, rd_addr;
	logic [CNT_W-1:0]  cnt_q, ref_dist;
	logic              lit_q, done_q;
	logic [7:0]        lit_byte_q, cur_byte;
	logic [WIN_AW-1:0] dist_m1_q;
	logic [LEN_W-1:0]  rem_q;
	logic [63:0]       acc_q, acc_new;
	logic [3:0]        used_q;
	logic              last_byte, complete, slot_free, produce, rd_en;
	logic              ov_q;

	assign ref_dist  = {1'b0, dist_m1_q} + 1'b1;
	assign rd_addr   = wp_q - dist_m1_q - 1'b1;
	assign rd_en     = (st_q == ST_RD);
	assign cur_byte  = lit_q ? lit_byte_q : ((cnt_q < ref_dist) ? 8'd0 : rd_data_q);
	assign last_byte = (rem_q == 9'd1);
	assign complete  = last_byte || (used_q == 4'(OUT_LANES - 1));
	assign slot_free = !ov_q || !out_stall;
	assign produce   = (st_q == ST_PUT) && (!complete || slot_free);
	assign pop       = (st_q == ST_IDLE) && !empty;
	assign acc_new   = acc_q | ({56'd0, cur_byte} << {used_q[2:0], 3'b000});
	assign out_valid = ov_q;

	always_ff @(posedge clk) begin
		if (produce) hist_mem[wp_q] <= cur_byte;
		if (rd_en) rd_data_q <= hist_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lit_q      <= head_cmd.is_lit;
			lit_byte_q <= head_cmd.lit_byte;
			dist_m1_q  <= head_cmd.dist_m1;
			done_q     <= head_cmd.done;
		end
		if (produce && complete) begin
			out_bytes   <= acc_new;
			byte_count  <= used_q + 4'd1;
			last_of_run <= last_byte;
			stream_done <= last_byte && done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			wp_q   <= '0;
			cnt_q  <= '0;
			rem_q  <= '0;
			acc_q  <= '0;
			used_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (produce && complete) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (pop) begin
						rem_q <= head_cmd.len;
						if (head_cmd.new_stream) begin
							wp_q  <= '0;
							cnt_q <= '0;
						end
						st_q <= head_cmd.is_lit ? ST_PUT : ST_RD;
					end
				end
				ST_RD: st_q <= ST_PUT;
				ST_PUT: begin
					if (produce) begin
						wp_q  <= wp_q + 1'b1;
						if (cnt_q != CNT_W'(WINDOW_DEPTH)) cnt_q <= cnt_q + 1'b1;
						rem_q <= rem_q - 1'b1;
						if (complete) begin
							acc_q  <= '0;
							used_q <= '0;
						end else begin
							acc_q  <= acc_new;
							used_q <= used_q + 4'd1;
						end
						st_q <= last_byte ? ST_IDLE : ST_RD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/yaz0d_checker.sv
// Port-level checks for the Yaz0 decompressor and the bind that attaches them.
module yaz0d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] out_bytes,
	input logic [3:0]  byte_count,
	input logic        last_of_run,
	input logic        stream_done
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_count >= 4'd1 && byte_count <= 4'd8))
		else $error("byte_count out of range");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_done |-> last_of_run)
		else $error("stream_done without last_of_run");

	a_full_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> byte_count == 4'd8)
		else $error("partial request before end of run");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_bytes))
		else $error("stalled request changed");

endmodule

bind yaz0_decompressor yaz0d_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_bytes, .byte_count,
	.last_of_run, .stream_done
);

FILE: dv/tb_yaz0_decompressor.sv
// Self-checking testbench for the Yaz0 decompressor: directed table, then random streams.
`timescale 1ns / 1ps

module tb_yaz0_decompressor;
	import yaz0d_pkg::*;

	// One output request as the checker sees it.
	typedef struct packed {
		logic [63:0] bytes;
		logic [3:0]  count;
		logic        last;
		logic        done;
	} out_req_t;

	// One row of the directed table. When has_exp is set, exp holds the single
	// request the row must produce, compared with the last request the prediction queued.
	typedef struct packed {
		logic [7:0] data;
		logic       sos;
		logic       has_exp;
		out_req_t   exp;
	} dir_row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        start_of_stream;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last_of_run;
	logic        stream_done;

	yaz0_decompressor DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .start_of_stream(start_of_stream),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_bytes(out_bytes), .byte_count(byte_count),
		.last_of_run(last_of_run), .stream_done(stream_done)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Predictor state: a private copy of the decoder's registers and window.
	logic [31:0] size_limit;
	logic        drop_header;
	logic [7:0]  window [WINDOW_DEPTH];
	logic [11:0] wr_ptr;
	logic [31:0] produced;
	logic [7:0]  code_bits;
	logic [3:0]  codes_left;
	phase_t      phase;
	logic [7:0]  ref_hi;
	logic [7:0]  ref_lo;
	logic [4:0]  hdr_left;
	logic        full_reached;

	out_req_t expected_q[$];
	int       mismatches;
	int       idle_cycles;
	bit       quiet;     // when set, neither side inserts idle bursts

	task automatic report(input string what);
		mismatches++;
		$display("ERROR at %0t: %s", $realtime, what);
	endtask

	function automatic bit is_full();
		return full_reached || produced >= size_limit;
	endfunction

	function automatic void consume_flag();
		code_bits  = code_bits << 1;
		codes_left = codes_left - 4'd1;
		phase      = (codes_left == 4'd0) ? PH_CODE : PH_FIRST;
	endfunction

	// Produces up to len bytes into the expectation queue. copy_dist of zero
	// means a literal; otherwise bytes are copied from copy_dist back.
	function automatic void produce(input logic [7:0] lit, input int copy_dist, input int len);
		out_req_t r;
		logic [7:0] b;
		int used;
		int n;
		r = '0;
		used = 0;
		n = 0;
		for (int i = 0; i < len && !is_full(); i++) begin
			if (copy_dist == 0) b = lit;
			else if (produced < copy_dist) b = 8'h00;
			else b = window[wr_ptr - copy_dist[11:0]];
			window[wr_ptr] = b;
			wr_ptr = wr_ptr + 12'd1;
			produced++;
			r.bytes[8*used +: 8] = b;
			used++;
			if (produced >= size_limit) full_reached = 1'b1;
			if (used == OUT_LANES || full_reached || i + 1 == len) begin
				r.count = used[3:0];
				r.done  = full_reached;
				expected_q.push_back(r);
				n++;
				r = '0;
				used = 0;
			end
		end
		if (n > 0) expected_q[$].last = 1'b1;
	endfunction

	// Advances the predictor by one accepted compressed byte.
	function automatic void decode_byte(input logic [7:0] b, input logic sos);
		int copy_dist;
		if (sos) begin
			wr_ptr = '0;
			produced = '0;
			code_bits = '0;
			codes_left = '0;
			phase = PH_CODE;
			full_reached = 1'b0;
			hdr_left = drop_header ? HEADER_BYTES : 5'd0;
		end
		if (is_full()) return;
		if (hdr_left != 0) begin
			hdr_left--;
			return;
		end
		copy_dist = {ref_hi[3:0], ref_lo} + 1;
		case (phase)
			PH_CODE: begin
				code_bits = b;
				codes_left = 4'd8;
				phase = PH_FIRST;
			end
			PH_FIRST: begin
				if (code_bits[7]) begin
					consume_flag();
					produce(b, 0, 1);
				end else begin
					ref_hi = b;
					phase = PH_SECOND;
				end
			end
			PH_SECOND: begin
				ref_lo = b;
				if (ref_hi[7:4] == 4'd0) begin
					phase = PH_THIRD;
				end else begin
					copy_dist = {ref_hi[3:0], ref_lo} + 1;
					consume_flag();
					produce(8'h00, copy_dist, ref_hi[7:4] + 2);
				end
			end
			default: begin
				consume_flag();
				produce(8'h00, copy_dist, b + 18);
			end
		endcase
	endfunction

	// Output side: random stall bursts, compare every accepted request.
	initial begin
		out_req_t got;
		out_req_t want;
		int burst;
		out_stall <= 1'b0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got = '{out_bytes, byte_count, last_of_run, stream_done};
				if (expected_q.size() == 0) begin
					report($sformatf("unexpected request %h", got));
				end else begin
					want = expected_q.pop_front();
					if (got.bytes !== want.bytes)
						report($sformatf("out_bytes %h, want %h", got.bytes, want.bytes));
					if (got.count !== want.count)
						report($sformatf("byte_count %0d, want %0d", got.count, want.count));
					if (got.last !== want.last)
						report($sformatf("last_of_run %b, want %b", got.last, want.last));
					if (got.done !== want.done)
						report($sformatf("stream_done %b, want %b", got.done, want.done));
				end
			end
			if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which neither channel accepts anything.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Sends one compressed byte, with an optional idle burst first; waits for
	// acceptance and updates the predictor.
	task automatic send_byte(input logic [7:0] b, input logic sos);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		start_of_stream <= sos;
		do @(posedge clk); while (in_stall);
		decode_byte(b, sos);
	endtask

	// Waits until every predicted request has arrived, then lets the engine settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_OUT_SIZE) size_limit = val;
		else drop_header = val[0];
	endtask

	// One random stream: a start byte, the rest of a header when hdr is set, then code bytes with
	// random flags, literals and back-references mostly reaching inside what was produced.
	task automatic random_stream(input int n_codes, input bit hdr);
		logic [7:0] code;
		int copy_dist;
		int len;
		send_byte($urandom_range(0, 255), 1'b1);
		if (hdr) for (int i = 0; i < 15; i++) send_byte($urandom_range(0, 255), 1'b0);
		for (int c = 0; c < n_codes; c++) begin
			code = $urandom_range(0, 255);
			send_byte(code, c == 0 && !hdr ? 1'b0 : 1'b0);
			for (int f = 7; f >= 0; f--) begin
				if (code[f]) begin
					send_byte($urandom_range(0, 255), 1'b0);
				end else begin
					copy_dist = (produced > 0 && $urandom_range(0, 3) != 0) ?
						$urandom_range(0, produced > 4095 ? 4095 : produced - 1) :
						$urandom_range(0, 4095);
					if ($urandom_range(0, 5) == 0) begin
						len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
							: $urandom_range(0, 20);
						send_byte({4'h0, copy_dist[11:8]}, 1'b0);
						send_byte(copy_dist[7:0], 1'b0);
						send_byte(len[7:0], 1'b0);
					end else begin
						len = $urandom_range(1, 15);
						send_byte({len[3:0], copy_dist[11:8]}, 1'b0);
						send_byte(copy_dist[7:0], 1'b0);
					end
				end
			end
		end
	endtask

	// Directed table: single-request rows carry their expected request.
	localparam int N_DIR = 22;
	localparam dir_row_t DIRECTED [N_DIR] = '{
		'{8'h00, 1'b1, 1'b0, '0},             // code byte: all references
		'{8'h00, 1'b0, 1'b0, '0},             // three-byte form, distance 1
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b0, '0},             // length 273 of zero history
		'{8'hFF, 1'b1, 1'b0, '0},             // restart: all literals
		'{8'h00, 1'b0, 1'b1, '{64'h0, 4'd1, 1'b1, 1'b0}},
		'{8'hFF, 1'b0, 1'b1, '{64'hFF, 4'd1, 1'b1, 1'b0}},
		'{8'hA5, 1'b0, 1'b1, '{64'hA5, 4'd1, 1'b1, 1'b0}},
		'{8'h5A, 1'b0, 1'b1, '{64'h5A, 4'd1, 1'b1, 1'b0}},
		'{8'h01, 1'b0, 1'b1, '{64'h01, 4'd1, 1'b1, 1'b0}},
		'{8'h80, 1'b0, 1'b1, '{64'h80, 4'd1, 1'b1, 1'b0}},
		'{8'h7F, 1'b0, 1'b1, '{64'h7F, 4'd1, 1'b1, 1'b0}},
		'{8'hFE, 1'b0, 1'b1, '{64'hFE, 4'd1, 1'b1, 1'b0}},
		'{8'h00, 1'b0, 1'b0, '0},             // code byte: references
		'{8'hF0, 1'b0, 1'b0, '0},             // length 17, distance 1
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h1F, 1'b0, 1'b0, '0},             // distance 4096, before start
		'{8'hFF, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},             // three-byte form, minimum long
		'{8'h07, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h0F, 1'b0, 1'b0, '0}              // reference left open at the end
	};

	initial begin
		out_req_t want;
		bit have_row_exp;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		start_of_stream = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		size_limit = '0;
		drop_header = 1'b1;
		wr_ptr = '0;
		produced = '0;
		code_bits = '0;
		codes_left = '0;
		phase = PH_CODE;
		ref_hi = '0;
		ref_lo = '0;
		hdr_left = HEADER_BYTES;
		full_reached = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Right after reset out_size is zero: bytes must be ignored.
		for (int i = 0; i < 3; i++) send_byte($urandom_range(0, 255), i == 0);
		wait_drained();

		write_reg(REG_SKIP_HEADER, 32'd0);
		write_reg(REG_OUT_SIZE, 32'd400);
		for (int i = 0; i < N_DIR; i++) begin
			have_row_exp = DIRECTED[i].has_exp;
			send_byte(DIRECTED[i].data, DIRECTED[i].sos);
			if (have_row_exp) begin
				want = expected_q[$];
				if (want !== DIRECTED[i].exp)
					report($sformatf("directed row %0d predicts %h", i, want));
			end
		end
		// A pause with the sender held until all output has come back.
		wait_drained();

		// Output cut off mid-run at a small size.
		write_reg(REG_OUT_SIZE, 32'd5);
		random_stream(1, 1'b0);
		wait_drained();

		// Random streams across sizes, up to the largest; one skips a header.
		for (int s = 0; s < 4; s++) begin
			if (s == 3) quiet = 1'b1;
			write_reg(REG_OUT_SIZE, s == 2 ? 32'hFFFF_FFFF : $urandom_range(20, 600));
			if (s == 1) write_reg(REG_SKIP_HEADER, 32'd1);
			if (s == 2) write_reg(REG_SKIP_HEADER, 32'd0);
			random_stream(1, s == 1);
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/yaz0d_pkg.sv
sv/yaz0d_fifo.sv
sv/yaz0d_front.sv
sv/yaz0d_back.sv
sv/yaz0_decompressor.sv
sv/yaz0d_checker.sv
dv/tb_yaz0_decompressor.sv
